[design/sph_poly6_density_sum_assert.svh]
// Assertion macros for the poly6 density block.
// Included by the RTL files that carry concurrent checks.
`ifndef SPH_POLY6_DENSITY_SUM_ASSERT_SVH
`define SPH_POLY6_DENSITY_SUM_ASSERT_SVH
`ifndef SYNTHESIS
`define SPD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("lbl failed");
`define SPD_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("lbl failed");
`else
`define SPD_ASSERT(lbl, clk, rst, prop)
`define SPD_ASSERT_RST(lbl, clk, prop)
`endif
`endif

[design/spd_pkg.sv]
// Package for the poly6 density block: sizes, payload structs, register codes.
// No dependencies.
package spd_pkg;
   localparam int MaxParticles = 1024;
   localparam int AddrW = $clog2(MaxParticles);
   localparam int CntW = $clog2(MaxParticles + 1);

   typedef enum logic [1:0] {
      CSR_COUNT = 2'd0,
      CSR_SCALE = 2'd1,
      CSR_COEFF = 2'd2
   } csr_addr_type;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [9:0]  index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [9:0]  particle;
      logic [63:0] density;
      logic [9:0]  nbr_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } pos_type;

   // One neighbour entering the kernel pipeline.
   typedef struct packed {
      logic    valid;
      pos_type own;
      pos_type nbr;
   } pair_type;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic [63:0] term;
   } term_type;
endpackage

[design/spd_store.sv]
// Position memory: one 96-bit word per particle slot, registered read.
// Depends on spd_pkg.
module spd_store
   import spd_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  pos_type          wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output pos_type          rd_data
);
   pos_type mem [MaxParticles];
   pos_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

[design/spd_kernel.sv]
// Pipelined poly6 kernel: pair of positions in, kernel term and hit flag out.
// Depends on spd_pkg; every multiply is followed by a register.
module spd_kernel
   import spd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] scale,
   input  logic [63:0] coeff,
   input  pair_type    pair,
   output term_type    result
);
   // Stage 1: axis magnitudes.
   logic        v1_ff;
   logic [32:0] m_ff [3];
   // Stage 2: scaled distances.
   logic        v2_ff;
   logic [64:0] c_ff [3];
   // Stage 3: squares.
   logic        v3_ff, ok3_ff;
   logic [63:0] sq_ff [3];
   // Stage 4: u^2 and t.
   logic        v4_ff, ok4_ff;
   logic [31:0] t4_ff;
   logic        v5_ff, ok5_ff;
   logic [31:0] t5_ff, t2_ff;
   logic [63:0] t3p_ff;
   logic        v6_ff, ok6_ff;
   logic [31:0] t3_ff;
   logic        v7_ff, ok7_ff;
   logic [63:0] lo_ff, hi_ff;

   logic [31:0] own_a [3], nbr_a [3];
   logic [32:0] m_in [3];
   logic [65:0] u2_in;
   logic        ok3_in;
   logic [63:0] t2p_in;

   assign own_a[0] = pair.own.x;
   assign own_a[1] = pair.own.y;
   assign own_a[2] = pair.own.z;
   assign nbr_a[0] = pair.nbr.x;
   assign nbr_a[1] = pair.nbr.y;
   assign nbr_a[2] = pair.nbr.z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [32:0] d;
         d = {own_a[k][31], own_a[k]} - {nbr_a[k][31], nbr_a[k]};
         m_in[k] = d[32] ? 33'(-d) : 33'(d);
      end
      ok3_in = (c_ff[0][64:32] == '0) && (c_ff[1][64:32] == '0)
             && (c_ff[2][64:32] == '0);
      u2_in = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      t2p_in = t4_ff * t4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0;
      end else begin
         v1_ff <= pair.valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff;
      end
      for (int k = 0; k < 3; k++) begin
         m_ff[k] <= m_in[k];
         c_ff[k] <= 65'(m_ff[k]) * 65'(scale);
         sq_ff[k] <= c_ff[k][31:0] * c_ff[k][31:0];
      end
      ok3_ff <= ok3_in;
      ok4_ff <= ok3_ff && (u2_in[65:64] == 2'b00);
      t4_ff  <= 32'h8000_0000 - 32'(u2_in[63:33]);
      ok5_ff <= ok4_ff;
      t5_ff  <= t4_ff;
      t2_ff  <= 32'(t2p_in >> 31);
      ok6_ff <= ok5_ff;
      t3p_ff <= t2_ff * t5_ff;
      ok7_ff <= ok6_ff;
      t3_ff  <= 32'(t3p_ff >> 31);
      lo_ff  <= coeff[31:0] * t3_ff;
      hi_ff  <= coeff[63:32] * t3_ff;
   end

   // ok7 tracks the t3 stage, so the coefficient product lines up one later.
   logic v8_ff, ok8_ff;
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else       v8_ff <= v7_ff;
      ok8_ff <= ok7_ff;
   end

   assign result.valid = v8_ff;
   assign result.hit   = ok8_ff;
   assign result.term  = (hi_ff << 1) + (lo_ff >> 31);
endmodule

[design/sph_poly6_density_sum.sv]
// Poly6 density sum. A load writes its slot and the block is ready again at once.
// A query reads its own slot, then streams slots 0..n-1 (n = particle_count, at most
// 1024) from the position memory, one per cycle, through an eight-stage kernel
// pipeline, and takes no new request until its result word is registered. A query
// that ends while a result still waits in the output register holds there.
// Synchronous reset clears control state and configuration (scale to 65536) only.
module sph_poly6_density_sum
   import spd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
`include "sph_poly6_density_sum_assert.svh"

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_OWN  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type      state_ff, state_in;
   logic [CntW-1:0] count_ff;
   logic [31:0]    scale_ff;
   logic [63:0]    coeff_ff;
   logic [AddrW-1:0] qidx_ff;
   logic [CntW-1:0] j_ff, n_ff;
   logic [CntW-1:0] j_in;
   pos_type        own_ff;
   logic           own_wait_ff;
   logic           rd_vld_ff, rd_skip_ff;
   logic [63:0]    dens_ff;
   logic [9:0]     cnt_ff;
   logic [4:0]     drain_ff;
   logic           rsp_vld_ff;
   rsp_type        rsp_ff;

   logic           accept;
   logic           finish;
   logic [AddrW-1:0] rd_addr;
   pos_type        rd_data;
   pos_type        wr_pos;
   pair_type       pair;
   term_type       term;
   logic [64:0]    sum;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // The sweep is complete; the word leaves once the output register is free.
   assign finish    = (state_ff == ST_DRAIN) && (drain_ff == '0)
                    && (!rsp_vld_ff || rsp_ready);

   assign wr_pos.x = req_data.pos_x;
   assign wr_pos.y = req_data.pos_y;
   assign wr_pos.z = req_data.pos_z;

   spd_store u_store (
      .clock   (clock),
      .wr_en   (accept && req_data.cmd == CMD_LOAD),
      .wr_addr (req_data.index),
      .wr_data (wr_pos),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rd_addr = (state_ff == ST_SCAN) ? j_ff[AddrW-1:0] : req_data.index;
      j_in = j_ff + 1'b1;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && req_data.cmd == CMD_QUERY) state_in = ST_OWN;
         ST_OWN:   state_in = (n_ff == '0) ? ST_DRAIN : ST_SCAN;
         ST_SCAN:  if (j_in >= n_ff) state_in = ST_DRAIN;
         ST_DRAIN: if (finish) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign pair.valid = rd_vld_ff && !rd_skip_ff;
   assign pair.own   = own_ff;
   assign pair.nbr   = rd_skip_ff ? own_ff : rd_data;
   assign sum = {1'b0, dens_ff} + {1'b0, term.term};

   spd_kernel u_kernel (
      .clock  (clock),
      .reset  (reset),
      .scale  (scale_ff),
      .coeff  (coeff_ff),
      .pair   (pair),
      .result (term)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         scale_ff   <= 32'd65536;
         coeff_ff   <= '0;
         rsp_vld_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         own_wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_COUNT: count_ff <= csr_data[CntW-1:0];
               CSR_SCALE: scale_ff <= csr_data[31:0];
               CSR_COEFF: coeff_ff <= csr_data;
               default: ;
            endcase
         end
         own_wait_ff <= accept && req_data.cmd == CMD_QUERY;
         rd_vld_ff   <= (state_ff == ST_SCAN);
         if (finish) rsp_vld_ff <= 1'b1;
         else if (rsp_ready) rsp_vld_ff <= 1'b0;
      end
      rd_skip_ff <= (j_ff[AddrW-1:0] == qidx_ff);
      if (own_wait_ff) own_ff <= rd_data;
      if (accept) begin
         qidx_ff <= req_data.index;
         j_ff    <= '0;
         n_ff    <= (count_ff > CntW'(MaxParticles)) ? CntW'(MaxParticles) : count_ff;
         dens_ff <= '0;
         cnt_ff  <= '0;
      end else if (state_ff == ST_SCAN) begin
         j_ff <= j_in;
      end
      if (state_ff != ST_DRAIN) drain_ff <= 5'd12;
      else if (drain_ff != '0) drain_ff <= drain_ff - 1'b1;
      if (term.valid && term.hit) begin
         dens_ff <= sum[64] ? '1 : sum[63:0];
         if (cnt_ff != 10'd1023) cnt_ff <= cnt_ff + 1'b1;
      end
      if (finish) begin
         rsp_ff.particle  <= qidx_ff;
         rsp_ff.density   <= dens_ff;
         rsp_ff.nbr_count <= cnt_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `SPD_ASSERT(a_no_accept_busy, clock, reset, (state_ff != ST_IDLE) |-> !req_ready)
   `SPD_ASSERT(a_rsp_after_drain, clock, reset, $rose(rsp_vld_ff) |-> $past(state_ff == ST_DRAIN))
   `SPD_ASSERT(a_no_scan_term_idle, clock, reset, (state_ff == ST_IDLE) |-> !rd_vld_ff)
   `SPD_ASSERT_RST(a_reset_idle, clock, $past(reset) |-> (state_ff == ST_IDLE && !rsp_vld_ff))
endmodule
